// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms clocked on clk, ORP_ASSERT gated by rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ORP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define ORP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/orp_pkg.sv -----
// ----------------------------------------------------------------------------
// orp_pkg
// types and constants of the overcurrent retry protector
// ----------------------------------------------------------------------------
package orp_pkg;

  localparam int unsigned TICK_W = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned STEP_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 3'd0,
    CFG_OBSERVE  = 3'd1,
    CFG_RETRY    = 3'd2,
    CFG_LOCKOUT  = 3'd3,
    CFG_WANT_CH  = 3'd4,
    CFG_WANT_AL  = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_DEBOUNCE = 2'd1,
    MODE_OBSERVE  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    LVL_NORMAL  = 2'd0,
    LVL_TRY1    = 2'd1,
    LVL_TRY2    = 2'd2,
    LVL_LOCKOUT = 2'd3
  } level_t;

  localparam logic [STEP_W-1:0] STEP_0 = 3'd0;
  localparam logic [STEP_W-1:0] STEP_1 = 3'd1;
  localparam logic [STEP_W-1:0] STEP_2 = 3'd2;
  localparam logic [STEP_W-1:0] STEP_3 = 3'd3;
  localparam logic [STEP_W-1:0] STEP_4 = 3'd4;

  localparam logic [TICK_W-1:0] RST_DEBOUNCE = 16'd20;
  localparam logic [TICK_W-1:0] RST_OBSERVE  = 16'd1000;
  localparam logic [TICK_W-1:0] RST_RETRY    = 16'd3000;
  localparam logic [TICK_W-1:0] RST_LOCKOUT  = 16'd60000;

  typedef struct packed {
    logic [TICK_W-1:0] debounce_ticks;
    logic [TICK_W-1:0] observe_ticks;
    logic [TICK_W-1:0] retry_wait_ticks;
    logic [TICK_W-1:0] lockout_wait_ticks;
    logic              want_channel;
    logic              want_alarm;
  } cfg_t;

  typedef struct packed {
    level_t            level;
    logic [STEP_W-1:0] step;
    mode_t             mode;
    logic              hit;
    logic [TICK_W-1:0] countdown;
    logic              fail;
    logic              channel;
    logic              alarm;
  } state_t;

endpackage

// ----- design/overcurrent_retry_protector_unit.sv -----
// ----------------------------------------------------------------------------
// overcurrent_retry_protector_unit
// hiccup overcurrent protection with retry levels for two 12 V switches
// ----------------------------------------------------------------------------
// Each input word is one tick of the overcurrent sense pin; each tick gives
// exactly one result word with both switch drives, the failure latch, the
// protection level and the phase within it. A new tick is taken every clock
// while the output is not stalled: the word is held in the input register,
// the detector and sequencer update in one pass, and the new state is the
// result register. Output stall holds the result and backs up into the
// input register. Configuration writes take effect at the next tick and
// must be made while no tick is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module overcurrent_retry_protector_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_overcurrent_sense,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_channel_drive,
  output logic                          out_alarm_drive,
  output logic                          out_failure,
  output logic [1:0]                    out_protection_level,
  output logic [orp_pkg::STEP_W-1:0]    out_phase,
  input  logic                          cfg_wr_en,
  input  logic [orp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [orp_pkg::TICK_W-1:0]    cfg_data
);
  import orp_pkg::*;

  cfg_t   cfg;
  state_t state_r;
  state_t state_nxt;
  logic   in_valid_r;
  logic   sense_r;
  logic   out_valid_r;
  logic   advance;

  orp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  orp_step u_step (
    .cur   (state_r),
    .cfg   (cfg),
    .sense (sense_r),
    .nxt   (state_nxt)
  );

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        in_valid_r <= 1'b1;
        sense_r    <= in_overcurrent_sense;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_channel_drive    = state_r.channel;
  assign out_alarm_drive      = state_r.alarm;
  assign out_failure          = state_r.fail;
  assign out_protection_level = state_r.level;
  assign out_phase            = state_r.step;

  `ORP_ASSERT(a_fail_sticky, state_r.fail |=> state_r.fail, "failure latch cleared")
  `ORP_ASSERT(a_fail_off, state_r.fail |-> (!state_r.channel && !state_r.alarm), "drive on after failure")
  `ORP_ASSERT(a_normal_step, (state_r.level == LVL_NORMAL) |-> (state_r.step <= STEP_2), "bad normal step")
  `ORP_ASSERT_ALWAYS(a_stall_src, in_stall |-> (in_valid_r && out_valid_r && out_stall), "stall without backlog")

endmodule

// ----- design/orp_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// orp_cfg_regs
// configuration register file, write only, values masked to register width
// ----------------------------------------------------------------------------
module orp_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [orp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [orp_pkg::TICK_W-1:0]      cfg_data,
  output orp_pkg::cfg_t                   cfg
);
  import orp_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks     <= RST_DEBOUNCE;
      cfg_r.observe_ticks      <= RST_OBSERVE;
      cfg_r.retry_wait_ticks   <= RST_RETRY;
      cfg_r.lockout_wait_ticks <= RST_LOCKOUT;
      cfg_r.want_channel       <= 1'b1;
      cfg_r.want_alarm         <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_DEBOUNCE: cfg_r.debounce_ticks     <= cfg_data;
        CFG_OBSERVE:  cfg_r.observe_ticks      <= cfg_data;
        CFG_RETRY:    cfg_r.retry_wait_ticks   <= cfg_data;
        CFG_LOCKOUT:  cfg_r.lockout_wait_ticks <= cfg_data;
        CFG_WANT_CH:  cfg_r.want_channel       <= cfg_data[0];
        CFG_WANT_AL:  cfg_r.want_alarm         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/orp_step.sv -----
// ----------------------------------------------------------------------------
// orp_step
// one tick of detector and protection sequencer, next state from current
// ----------------------------------------------------------------------------
module orp_step (
  input  orp_pkg::state_t cur,
  input  orp_pkg::cfg_t   cfg,
  input  logic            sense,
  output orp_pkg::state_t nxt
);
  import orp_pkg::*;

  always_comb begin
    state_t s;
    logic   idle;
    logic   esc;
    logic   entry;
    s     = cur;
    esc   = 1'b0;
    entry = 1'b0;

    // detector
    unique case (s.mode)
      MODE_DEBOUNCE: begin
        if (s.countdown == '0) begin
          if (sense) s.hit = 1'b1;
          s.mode = MODE_IDLE;
        end else begin
          s.countdown = s.countdown - 1'b1;
        end
      end
      MODE_OBSERVE: begin
        if (sense) begin
          s.hit  = 1'b1;
          s.mode = MODE_IDLE;
        end else if (s.countdown == '0) begin
          s.mode = MODE_IDLE;
        end else begin
          s.countdown = s.countdown - 1'b1;
        end
      end
      default: ;
    endcase

    idle = (s.mode != MODE_DEBOUNCE) && (s.mode != MODE_OBSERVE);

    // sequencer
    if (s.level == LVL_NORMAL) begin
      unique case (s.step)
        STEP_0: begin
          if (sense) begin
            s.countdown = cfg.debounce_ticks;
            s.mode      = MODE_DEBOUNCE;
            s.hit       = 1'b0;
            s.step      = STEP_1;
          end
        end
        STEP_1: begin
          if (idle) begin
            if (s.hit) begin
              esc = 1'b1;
            end else begin
              s.countdown = cfg.observe_ticks;
              s.mode      = MODE_OBSERVE;
              s.hit       = 1'b0;
              s.step      = STEP_2;
            end
          end
        end
        STEP_2: begin
          if (idle) begin
            if (s.hit) esc = 1'b1;
            else       s.step = STEP_0;
          end
        end
        default: s.step = STEP_0;
      endcase
    end else begin
      unique case (s.step)
        STEP_0: entry = 1'b1;
        STEP_1: begin
          if (idle) begin
            s.countdown = (s.level == LVL_LOCKOUT) ? cfg.lockout_wait_ticks
                                                   : cfg.retry_wait_ticks;
            s.mode      = MODE_OBSERVE;
            s.step      = STEP_2;
          end
        end
        STEP_2: begin
          if (idle) begin
            if (s.hit) begin
              s.fail  = 1'b1;
              s.level = LVL_LOCKOUT;
              s.step  = STEP_0;
            end else begin
              if (cfg.want_alarm && !s.fail)   s.alarm   = 1'b1;
              if (cfg.want_channel && !s.fail) s.channel = 1'b1;
              s.countdown = cfg.debounce_ticks;
              s.mode      = MODE_DEBOUNCE;
              s.hit       = 1'b0;
              s.step      = STEP_3;
            end
          end
        end
        STEP_3: begin
          if (idle) begin
            if (s.hit) begin
              esc = 1'b1;
            end else begin
              s.countdown = cfg.observe_ticks;
              s.mode      = MODE_OBSERVE;
              s.hit       = 1'b0;
              s.step      = STEP_4;
            end
          end
        end
        STEP_4: begin
          if (idle) begin
            if (s.hit) begin
              esc = 1'b1;
            end else begin
              s.level = LVL_NORMAL;
              s.step  = STEP_0;
            end
          end
        end
        default: s.step = STEP_0;
      endcase
    end

    // escalation saturates at lockout, entry runs in the same tick
    if (esc) begin
      if (s.level != LVL_LOCKOUT) s.level = level_t'(s.level + 2'd1);
      entry = 1'b1;
    end

    if (entry) begin
      s.channel   = 1'b0;
      s.alarm     = 1'b0;
      s.countdown = cfg.debounce_ticks;
      s.mode      = MODE_DEBOUNCE;
      s.hit       = 1'b0;
      s.step      = STEP_1;
    end

    if (s.level == LVL_NORMAL) begin
      s.channel = cfg.want_channel && !s.fail;
      s.alarm   = cfg.want_alarm && !s.fail;
    end

    nxt = s;
  end

endmodule
